[hdl/deque_pkg.sv]
// Shared constants, command and status codes, and the transfer and
// control struct types for the double-ended queue. No dependencies.
`timescale 1ns / 1ps

package deque_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } deque_in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               found;
    logic [1:0]         status;
  } deque_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       scan_first;
    logic       scan_next;
    logic       ld_result;
    logic       res_from_mem;
    logic       res_found;
    logic [1:0] res_status;
  } deque_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic scan_last;
  } deque_stat_t;

endpackage

[hdl/double_ended_queue.sv]
// Double-ended queue: a sixteen-entry ring store of signed 32-bit values
// with push and pop at both ends and a linear search. A command transfers at
// a clock edge where start_i is high and busy_o is low. Every command gives
// one result, shown on result_o for one cycle with done_o high, in the cycle
// after the command's last step; it must be taken then. Pushes, failed pops,
// searches of an empty queue and unused codes never raise busy_o. A pop goes
// through the S_POP state, since the store has one registered read port. A
// search reads one entry per cycle from the front and stops at the first
// match or at the last entry. A new command may transfer while the previous
// result is on the result port. Depends on deque_pkg, deque_controller,
// deque_datapath.
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  deque_pkg::deque_in_t  item_i,
  output logic                  done_o,
  output deque_pkg::deque_out_t result_o
);
  import deque_pkg::*;

  deque_ctrl_t ctrl;
  deque_stat_t stat;

  deque_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (item_i.command),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  deque_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .result_o (result_o)
  );

  // A push into a store with room completes next cycle with status ok.
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !stat.full &&
     (item_i.command == CMD_PUSH_FRONT || item_i.command == CMD_PUSH_BACK))
    |=> (done_o && result_o.status == ST_OK && !result_o.found))
    else $error("push with room did not complete with status ok");

  // A pop from an empty queue answers at once with the empty status.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && stat.empty &&
     (item_i.command == CMD_POP_FRONT || item_i.command == CMD_POP_BACK))
    |=> (done_o && result_o.status == ST_EMPTY && result_o.data == '0))
    else $error("pop on empty queue gave a wrong result");

  // The store can never report full and empty at once.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("entry count is both full and empty");

  // A found flag only comes with zero data and status ok.
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |-> (result_o.data == '0 && result_o.status == ST_OK))
    else $error("search result carries data or an error status");

endmodule

[hdl/deque_datapath.sv]
// Datapath of the double-ended queue: ring store, front index, entry count,
// scan index and result register. Depends on deque_pkg.
`timescale 1ns / 1ps

module deque_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deque_pkg::deque_in_t  item_i,
  input  deque_pkg::deque_ctrl_t ctrl_i,
  output deque_pkg::deque_stat_t stat_o,
  output deque_pkg::deque_out_t result_o
);
  import deque_pkg::*;

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rdata_q;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] k_q;
  logic [31:0]      value_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             rd_en, wr_en;
  deque_out_t       result_q;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(DEPTH)) s = s - (IDX_W + 1)'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    if (a == '0) return IDX_W'(DEPTH - 1);
    return a - IDX_W'(1);
  endfunction

  assign cnt_m1 = count_q - CNT_W'(1);

  always_comb begin
    rd_addr = front_q;
    wr_addr = ring_dec(front_q);
    if (ctrl_i.pop_back) rd_addr = ring_add(front_q, cnt_m1[IDX_W-1:0]);
    if (ctrl_i.scan_next) rd_addr = ring_add(front_q, k_q + IDX_W'(1));
    if (ctrl_i.push_back) wr_addr = ring_add(front_q, count_q[IDX_W-1:0]);
  end

  assign wr_en = ctrl_i.push_front | ctrl_i.push_back;
  assign rd_en = ctrl_i.pop_front | ctrl_i.pop_back | ctrl_i.scan_first
               | ctrl_i.scan_next;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= item_i.value;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (ctrl_i.push_front) begin
      front_d = ring_dec(front_q);
      count_d = count_q + CNT_W'(1);
    end
    if (ctrl_i.push_back) count_d = count_q + CNT_W'(1);
    if (ctrl_i.pop_front) begin
      front_d = ring_add(front_q, IDX_W'(1));
      count_d = cnt_m1;
    end
    if (ctrl_i.pop_back) count_d = cnt_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // The scan index names the entry whose read data is in rdata_q.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_first) begin
      k_q     <= '0;
      value_q <= item_i.value;
    end else if (ctrl_i.scan_next) begin
      k_q <= k_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_result) begin
      result_q.data   <= ctrl_i.res_from_mem ? rdata_q : '0;
      result_q.found  <= ctrl_i.res_found;
      result_q.status <= ctrl_i.res_status;
    end
  end

  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.match     = (rdata_q == value_q);
  assign stat_o.scan_last = (CNT_W'(k_q) == cnt_m1);
  assign result_o         = result_q;

endmodule

[hdl/deque_controller.sv]
// Controller state machine of the double-ended queue: decodes commands,
// sequences pops and searches, and drives the result strobe. Depends on deque_pkg.
`timescale 1ns / 1ps

module deque_controller (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2:0]             command_i,
  input  deque_pkg::deque_stat_t stat_i,
  output deque_pkg::deque_ctrl_t ctrl_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import deque_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (command_i) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              ctrl_o.ld_result = 1'b1;
              if (stat_i.full) begin
                ctrl_o.res_status = ST_FULL;
              end else begin
                ctrl_o.push_front = (command_i == CMD_PUSH_FRONT);
                ctrl_o.push_back  = (command_i == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (stat_i.empty) begin
                ctrl_o.ld_result  = 1'b1;
                ctrl_o.res_status = ST_EMPTY;
              end else begin
                ctrl_o.pop_front = (command_i == CMD_POP_FRONT);
                ctrl_o.pop_back  = (command_i == CMD_POP_BACK);
                state_d = S_POP;
              end
            end
            CMD_SEARCH: begin
              if (stat_i.empty) begin
                ctrl_o.ld_result = 1'b1;
              end else begin
                ctrl_o.scan_first = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: ctrl_o.ld_result = 1'b1;
          endcase
        end
      end
      S_POP: begin
        ctrl_o.ld_result    = 1'b1;
        ctrl_o.res_from_mem = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        // One entry is compared per cycle while the next one is read.
        if (stat_i.match || stat_i.scan_last) begin
          ctrl_o.ld_result = 1'b1;
          ctrl_o.res_found = stat_i.match;
          state_d = S_IDLE;
        end else begin
          ctrl_o.scan_next = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ctrl_o.ld_result;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
